>>> rtl/core/rrc_pkg.sv
// package for the rotated rectangle corner block: trig constants and arctangent table
`default_nettype none
package rrc_pkg;
  localparam int AngleW = 17;
  localparam logic [AngleW-1:0] AngleFull = 17'd92160;
  localparam logic [AngleW-1:0] AngleQuarter = 17'd23040;
  localparam int TrigW = 19;
  localparam int ZW = 28;
  localparam int TableLen = 24;
  localparam logic signed [TrigW-1:0] CordicGain = 19'sd39797;
  localparam logic signed [TrigW-1:0] TrigOne = 19'sd65536;

  function automatic logic signed [ZW-1:0] atan_lookup(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0: v = 28'sd47185920;
      1: v = 28'sd27855475;
      2: v = 28'sd14718068;
      3: v = 28'sd7471121;
      4: v = 28'sd3750058;
      5: v = 28'sd1876857;
      6: v = 28'sd938658;
      7: v = 28'sd469357;
      8: v = 28'sd234682;
      9: v = 28'sd117342;
      10: v = 28'sd58671;
      11: v = 28'sd29335;
      12: v = 28'sd14668;
      13: v = 28'sd7334;
      14: v = 28'sd3667;
      15: v = 28'sd1833;
      16: v = 28'sd917;
      17: v = 28'sd458;
      18: v = 28'sd229;
      19: v = 28'sd115;
      20: v = 28'sd57;
      21: v = 28'sd29;
      22: v = 28'sd14;
      23: v = 28'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/rrc_cordic.sv
// pipelined rotation-mode cordic producing clamped cosine and sine in q1.16
`default_nettype none
module rrc_cordic #(
  parameter int TRIG_ITERATIONS = 16,
  parameter int PW = 98
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  en_i,
  input  wire                                  valid_i,
  input  wire [rrc_pkg::AngleW-1:0]            angle_i,
  input  wire [PW-1:0]                         pass_i,
  output logic                                 valid_o,
  output logic signed [rrc_pkg::TrigW-1:0]     cos_o,
  output logic signed [rrc_pkg::TrigW-1:0]     sin_o,
  output logic [PW-1:0]                        pass_o
);
  localparam int N = (TRIG_ITERATIONS < rrc_pkg::TableLen) ? TRIG_ITERATIONS
                                                           : rrc_pkg::TableLen;
  localparam int TW = rrc_pkg::TrigW;
  localparam int ZW = rrc_pkg::ZW;

  // stage 0: angle reduction and quadrant split
  logic              v0_q;
  logic [1:0]        q0_q;
  logic signed [ZW-1:0] z0_q;
  logic [PW-1:0]     p0_q;
  logic [rrc_pkg::AngleW-1:0] red_a, rem_a;
  logic [1:0]        quad;

  always_comb begin
    red_a = (angle_i >= rrc_pkg::AngleFull) ? angle_i - rrc_pkg::AngleFull : angle_i;
    quad = 2'd0;
    rem_a = red_a;
    if (red_a >= 3 * rrc_pkg::AngleQuarter) begin
      quad = 2'd3; rem_a = red_a - 17'(3 * rrc_pkg::AngleQuarter);
    end else if (red_a >= 2 * rrc_pkg::AngleQuarter) begin
      quad = 2'd2; rem_a = red_a - 17'(2 * rrc_pkg::AngleQuarter);
    end else if (red_a >= rrc_pkg::AngleQuarter) begin
      quad = 2'd1; rem_a = red_a - rrc_pkg::AngleQuarter;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q0_q <= quad;
      // remainder stays below a quarter turn, so the top bit dropped here is zero
      z0_q <= ZW'({rem_a, 12'd0});
      p0_q <= pass_i;
    end
  end

  // one iteration per stage
  logic              v_q [N+1];
  logic [1:0]        q_q [N+1];
  logic signed [TW-1:0] x_q [N+1];
  logic signed [TW-1:0] y_q [N+1];
  logic signed [ZW-1:0] z_q [N+1];
  logic [PW-1:0]     p_q [N+1];

  always_comb begin
    v_q[0] = v0_q;
    q_q[0] = q0_q;
    x_q[0] = rrc_pkg::CordicGain;
    y_q[0] = '0;
    z_q[0] = z0_q;
    p_q[0] = p0_q;
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    logic signed [TW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[i+1] <= q_q[i];
        p_q[i+1] <= p_q[i];
        if (!z_q[i][ZW-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - rrc_pkg::atan_lookup(i);
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + rrc_pkg::atan_lookup(i);
        end
      end
    end
  end

  // quadrant rotation and clamp
  logic signed [TW-1:0] cr, sr;
  always_comb begin
    case (q_q[N])
      2'd0: begin cr = x_q[N];  sr = y_q[N];  end
      2'd1: begin cr = -y_q[N]; sr = x_q[N];  end
      2'd2: begin cr = -x_q[N]; sr = -y_q[N]; end
      default: begin cr = y_q[N]; sr = -x_q[N]; end
    endcase
    if (cr > rrc_pkg::TrigOne) cr = rrc_pkg::TrigOne;
    if (cr < -rrc_pkg::TrigOne) cr = -rrc_pkg::TrigOne;
    if (sr > rrc_pkg::TrigOne) sr = rrc_pkg::TrigOne;
    if (sr < -rrc_pkg::TrigOne) sr = -rrc_pkg::TrigOne;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v_q[N];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o  <= cr;
      sin_o  <= sr;
      pass_o <= p_q[N];
    end
  end

  // cosine and sine stay on the unit range after the clamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (cos_o <= rrc_pkg::TrigOne && cos_o >= -rrc_pkg::TrigOne))
    else $error("cosine out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (sin_o <= rrc_pkg::TrigOne && sin_o >= -rrc_pkg::TrigOne))
    else $error("sine out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(valid_o))
    else $error("cordic valid moved during stall");
endmodule
`default_nettype wire

>>> rtl/core/rotated_rect_corners.sv
// rotated rectangle corners: cordic, product stage and four-corner serializer
//
// channel  dir  fields (tdata low to high)                 tuser / tlast
// s_axis   in   center_x, center_y, width, height, angle   -
// m_axis   out  corner_x, corner_y                          corner_index / last
//
// rectangles overlap in the pipe, but input stalls while the serializer holds one
// and is not sending its last corner; the result port emits one corner per cycle
// while m_axis_tready is high, so the four-corner serializer sets the rate.
// reset clears every valid bit; payload registers are not reset.
// an m_axis stall holds the pipe behind the serializer; nothing is lost or repeated.
`default_nettype none
module rotated_rect_corners #(
  parameter int COORD_WIDTH = 24,
  parameter int TRIG_ITERATIONS = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  // center_x, center_y, width, height, angle, zero pad
  input  wire [((4*COORD_WIDTH+17+7)/8)*8-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  // corner_x, corner_y, zero pad
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
  // corner_index
  output logic [1:0]            m_axis_tuser,
  output logic                  m_axis_tlast
);
  localparam int CW = COORD_WIDTH;
  localparam int TW = rrc_pkg::TrigW;
  localparam int PW = 4 * CW;
  localparam int MW = CW + TW;
  localparam int SW = CW + 3;
  localparam int OW = ((2*CW+7)/8)*8;

  // serializer: holds one rectangle's corners and emits them
  logic         hold_q;
  logic [1:0]   idx_q;
  logic         en;
  logic         cvalid;
  logic signed [TW-1:0] cs, sn;
  logic [PW-1:0] cpass;

  // pipe advances when the last stage is empty or about to be taken over
  logic         p2_v_q;
  logic         done_corner;
  assign done_corner = hold_q && m_axis_tready && idx_q == 2'd3;
  assign en = !p2_v_q || (!hold_q) || done_corner;
  assign s_axis_tready = en;

  rrc_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS), .PW(PW)) u_cordic (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid),
    .angle_i(s_axis_tdata[4*CW +: rrc_pkg::AngleW]),
    .pass_i(s_axis_tdata[PW-1:0]),
    .valid_o(cvalid), .cos_o(cs), .sin_o(sn), .pass_o(cpass)
  );

  // stage p1: four products
  logic p1_v_q;
  logic signed [MW-1:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [CW-1:0] cx1_q, cy1_q;
  logic signed [CW-1:0] w_in, h_in;
  assign w_in = cpass[2*CW +: CW];
  assign h_in = cpass[3*CW +: CW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p1_v_q <= 1'b0;
    else if (en) p1_v_q <= cvalid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q  <= MW'(w_in) * MW'(cs);
      pb_q  <= MW'(h_in) * MW'(sn);
      pc_q  <= MW'(w_in) * MW'(sn);
      pd_q  <= MW'(h_in) * MW'(cs);
      cx1_q <= cpass[0 +: CW];
      cy1_q <= cpass[CW +: CW];
    end
  end

  // round to nearest, ties away from zero, after dividing by 2^17
  function automatic logic signed [MW-1:0] rnd(input logic signed [MW-1:0] p);
    logic [MW-1:0] m;
    logic [MW-1:0] r;
    m = p[MW-1] ? MW'(-p) : MW'(p);
    r = (m + (MW'(1) << 16)) >> 17;
    return p[MW-1] ? -$signed(r) : $signed(r);
  endfunction

  // stage p2: rounded terms held while corners go out
  logic signed [MW-1:0] a2_q, b2_q, c2_q, d2_q;
  logic signed [CW-1:0] cx2_q, cy2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p2_v_q <= 1'b0;
    else if (en) p2_v_q <= p1_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      a2_q <= rnd(pa_q); b2_q <= rnd(pb_q);
      c2_q <= rnd(pc_q); d2_q <= rnd(pd_q);
      cx2_q <= cx1_q; cy2_q <= cy1_q;
    end
  end

  // corner sums with saturation
  logic signed [SW-1:0] sx, sy;
  logic signed [CW-1:0] ox, oy;
  logic signed [SW-1:0] hi, lo;
  always_comb begin
    hi = SW'((SW'(1) <<< (CW-1)) - 1);
    lo = -hi - SW'(1);
    case (idx_q)
      2'd0: begin
        sx = SW'(cx2_q) - SW'(a2_q) + SW'(b2_q);
        sy = SW'(cy2_q) - SW'(c2_q) - SW'(d2_q);
      end
      2'd1: begin
        sx = SW'(cx2_q) + SW'(a2_q) + SW'(b2_q);
        sy = SW'(cy2_q) + SW'(c2_q) - SW'(d2_q);
      end
      2'd2: begin
        sx = SW'(cx2_q) + SW'(a2_q) - SW'(b2_q);
        sy = SW'(cy2_q) + SW'(c2_q) + SW'(d2_q);
      end
      default: begin
        sx = SW'(cx2_q) - SW'(a2_q) - SW'(b2_q);
        sy = SW'(cy2_q) - SW'(c2_q) + SW'(d2_q);
      end
    endcase
    ox = (sx > hi) ? CW'(hi) : (sx < lo) ? CW'(lo) : CW'(sx);
    oy = (sy > hi) ? CW'(hi) : (sy < lo) ? CW'(lo) : CW'(sy);
  end

  // output register loads a corner when empty or taken
  logic           ov_q;
  logic [OW-1:0]  od_q;
  logic [1:0]     ou_q;
  logic           ol_q;
  logic           take;
  assign take = hold_q && (!ov_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      idx_q  <= 2'd0;
      ov_q   <= 1'b0;
    end else begin
      if (take) begin
        ov_q  <= 1'b1;
        idx_q <= idx_q + 2'd1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
      if (en) hold_q <= p1_v_q;
      else if (take && idx_q == 2'd3) hold_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (take) begin
      od_q <= OW'({oy, ox});
      ou_q <= idx_q;
      ol_q <= (idx_q == 2'd3);
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ou_q;
  assign m_axis_tlast  = ol_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 2'd3)))
    else $error("last flag disagrees with corner index");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hold_q |-> idx_q == 2'd0)
    else $error("corner counter not at zero while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast && !take) |=> !m_axis_tvalid)
    else $error("corner output repeated");
endmodule
`default_nettype wire

>>> bench/rotated_rect_corners_tb.sv
// testbench for rotated_rect_corners: predicts the four rotated corners of each rectangle
`default_nettype none

class corner_board;
  typedef struct packed {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic [1:0] idx;
    logic last;
  } corner_t;

  corner_t pending[$];
  int errors;

  function automatic longint rshift_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_prod(longint a, longint t);
    bit neg;
    longint ma, mt, m;
    neg = (a < 0) != (t < 0);
    ma = a < 0 ? -a : a;
    mt = t < 0 ? -t : t;
    m = (ma * mt + (64'sd1 <<< 16)) >>> 17;
    return neg ? -m : m;
  endfunction

  function automatic longint sat_coord(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint clamp_trig(longint v);
    if (v > 65536) return 65536;
    if (v < -65536) return -65536;
    return v;
  endfunction

  // cordic in q1.16, then quadrant rotation and clamp
  function automatic void trig(input logic [16:0] ang, output longint c, output longint s);
    longint a, q, r, x, y, z, dx, dy, tc, ts;
    a = ang;
    if (a >= rrc_pkg::AngleFull) a -= rrc_pkg::AngleFull;
    q = a / rrc_pkg::AngleQuarter;
    r = a - q * rrc_pkg::AngleQuarter;
    z = r <<< 12;
    x = rrc_pkg::CordicGain;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = rshift_floor(y, i);
      dy = rshift_floor(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(rrc_pkg::atan_lookup(i));
      end else begin
        x += dx; y -= dy; z += longint'(rrc_pkg::atan_lookup(i));
      end
    end
    case (q & 3)
      0: begin tc = x;  ts = y;  end
      1: begin tc = -y; ts = x;  end
      2: begin tc = -x; ts = -y; end
      default: begin tc = y; ts = -x; end
    endcase
    c = clamp_trig(tc);
    s = clamp_trig(ts);
  endfunction

  function void note_rect(logic signed [23:0] cx, logic signed [23:0] cy,
                          logic signed [23:0] w, logic signed [23:0] h, logic [16:0] ang);
    longint c, s, pa, pb, pc, pd, sx, sy;
    corner_t e;
    trig(ang, c, s);
    pa = round_prod(w, c);
    pb = round_prod(h, s);
    pc = round_prod(w, s);
    pd = round_prod(h, c);
    for (int k = 0; k < 4; k++) begin
      sx = (k == 1 || k == 2) ? 1 : -1;
      sy = (k >= 2) ? 1 : -1;
      e.cx = 24'(sat_coord(cx + sx * pa - sy * pb));
      e.cy = 24'(sat_coord(cy + sx * pc + sy * pd));
      e.idx = 2'(k);
      e.last = (k == 3);
      pending.push_back(e);
    end
  endfunction

  function void check_corner(logic signed [23:0] x, logic signed [23:0] y,
                             logic [1:0] idx, logic last);
    corner_t e;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected corner x=%0d y=%0d idx=%0d", x, y, idx);
      return;
    end
    e = pending.pop_front();
    if (e.cx !== x || e.cy !== y || e.idx !== idx || e.last !== last) begin
      errors++;
      if (errors <= 10)
        $display("corner mismatch: exp x=%0d y=%0d idx=%0d last=%0d got x=%0d y=%0d idx=%0d last=%0d",
                 e.cx, e.cy, e.idx, e.last, x, y, idx, last);
    end
  endfunction
endclass

module rotated_rect_corners_tb;
  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [119:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;
  logic sink_running;
  corner_board board;

  rotated_rect_corners u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 4095) - 2048);
      default: return 24'($urandom);
    endcase
  endfunction

  // valid stays high between back-to-back requests and drops for a gap or in drop_valid
  task automatic send_rect(logic [23:0] cx, logic [23:0] cy, logic [23:0] w,
                           logic [23:0] h, logic [16:0] ang, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tdata <= {7'd0, ang, h, w, cy, cx};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_rect(cx, cy, w, h, ang);
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_corner(m_axis_tdata[23:0], m_axis_tdata[47:24], m_axis_tuser, m_axis_tlast);

  // random backpressure on the corner side while sink_running is set, else ready high
  initial begin
    int g;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!sink_running) begin
        m_axis_tready <= 1'b1;
      end else begin
        g = gap_len();
        if (g == 0) m_axis_tready <= 1'b1;
        else begin
          m_axis_tready <= 1'b0;
          repeat (g - 1) @(negedge clk_i);
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("rotated_rect_corners regression: fail");
    $finish;
  end

  initial begin
    logic [16:0] angs[12];
    int waited;
    board = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    sink_running = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    angs = '{17'd0, 17'd23040, 17'd46080, 17'd69120, 17'd92159, 17'd92160, 17'd131071,
             17'd115200, 17'd11520, 17'd1, 17'd23039, 17'd100000};
    // directed: quadrant edges, wrapped angles, extreme sizes, mirrored sizes
    foreach (angs[i]) send_rect(24'd0, 24'd0, 24'd2560, 24'd1280, angs[i], 0);
    send_rect(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff, 17'd11520, 0);
    send_rect(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 17'd0, 0);
    send_rect(24'h800000, 24'h7fffff, 24'h800000, 24'h800000, 17'd34560, 0);
    send_rect(24'd1000, -24'sd1000, -24'sd5120, 24'd2560, 17'd5000, 0);
    send_rect(24'd0, 24'd0, 24'h800000, 24'h7fffff, 17'd131071, 0);
    send_rect(24'h123456, 24'hfedcba, 24'hffffff, 24'd1, 17'd65535, 0);
    send_rect(24'd0, 24'd0, 24'd0, 24'd0, 17'd46080, 0);
    sink_running = 1'b1;
    for (int n = 0; n < 370; n++) begin
      send_rect(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                17'($urandom_range(0, 131071)), 1);
      if (n == 180) begin
        drop_valid();
        while (board.pending.size() != 0) @(posedge clk_i);
      end
      if (n == 300) sink_running = 1'b0;
    end
    drop_valid();
    sink_running = 1'b1;
    waited = 0;
    while (board.pending.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (40) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("rotated_rect_corners regression: pass");
    else
      $display("rotated_rect_corners regression: fail");
    $finish;
  end
endmodule

>>> files.f
rtl/core/rrc_pkg.sv
rtl/core/rrc_cordic.sv
rtl/core/rotated_rect_corners.sv
bench/rotated_rect_corners_tb.sv
